### rtl/hkbd_pkg.sv
// Package for the hash keystream byte decoder.
// Holds the finalizer constants, the sequencer state type and the byte decode function.
// No dependencies.
package hkbd_pkg;

    localparam logic [31:0] GOLDEN_STEP = 32'h9e3779b9;
    localparam logic [31:0] MIX_MUL_A   = 32'h7feb352d;
    localparam logic [31:0] MIX_MUL_B   = 32'h846ca68b;

    typedef enum logic [3:0] {
        MIX_IDLE   = 4'b0001,
        MIX_PASS_A = 4'b0010,
        MIX_PASS_B = 4'b0100,
        MIX_DONE   = 4'b1000
    } mix_state_t;

    typedef struct packed {
        logic start;
        logic ack;
    } mix_ctl_t;

    typedef struct packed {
        logic        done;
        logic [31:0] key;
    } mix_res_t;

    function automatic logic [7:0] decode_byte(input logic [7:0] cbyte, input logic [31:0] key);
        logic [7:0]  v;
        logic [15:0] dbl;
        logic [15:0] sh;
        v   = (cbyte - key[15:8]) ^ key[7:0];
        dbl = {v, v};
        sh  = dbl >> key[18:16];
        return sh[7:0];
    endfunction

endpackage

### rtl/hkbd_mix.sv
// Key word finalizer: xorshift-multiply mix over one shared 32-bit multiplier.
// A small sequencer runs the two multiply passes; depends on hkbd_pkg.
module hkbd_mix
    import hkbd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  mix_ctl_t    ctl,
    input  logic [31:0] word,
    output mix_res_t    res
);

    mix_state_t  state_reg, state_next;
    logic [31:0] opnd_reg, opnd_next;
    logic [31:0] prod_reg, prod_next;
    logic [31:0] mul_op;
    logic [31:0] mul_coef;
    logic [31:0] mul_res;

    always_comb
    begin
        if (state_reg == MIX_PASS_A)
        begin
            mul_op   = opnd_reg;
            mul_coef = MIX_MUL_A;
        end
        else
        begin
            mul_op   = prod_reg ^ (prod_reg >> 15);
            mul_coef = MIX_MUL_B;
        end
        mul_res = mul_op * mul_coef;
    end

    always_comb
    begin
        state_next = state_reg;
        opnd_next  = opnd_reg;
        prod_next  = prod_reg;
        unique case (state_reg)
            MIX_IDLE:
            begin
                if (ctl.start)
                begin
                    opnd_next  = word ^ (word >> 16);
                    state_next = MIX_PASS_A;
                end
            end
            MIX_PASS_A:
            begin
                prod_next  = mul_res;
                state_next = MIX_PASS_B;
            end
            MIX_PASS_B:
            begin
                prod_next  = mul_res;
                state_next = MIX_DONE;
            end
            MIX_DONE:
            begin
                if (ctl.ack)
                    state_next = MIX_IDLE;
            end
            default:
                state_next = MIX_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= MIX_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        opnd_reg <= opnd_next;
        prod_reg <= prod_next;
    end

    assign res.done = (state_reg == MIX_DONE);
    assign res.key  = prod_reg ^ (prod_reg >> 16);

endmodule

### rtl/hash_keystream_byte_decoder_top.sv
// Top level of the hash keystream byte decoder.
// Instantiates hkbd_mix; uses hkbd_pkg for constants and the byte decode function.
//
// The key word of each accepted beat goes through two passes of one shared 32-bit
// multiplier and then the byte is decoded into the output register. The input side is not
// ready while a beat is in work, so a new beat enters only once the last result is loaded
// into the output register. A result waiting on the output does not block the next beat
// from being accepted; only a second finished result waits for the output to drain. Writing
// cfg_wdata with cfg_we high sets the seed and restarts the offset at the seed.
module hash_keystream_byte_decoder_top
    import hkbd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata,       // key_seed
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,    // [7:0] cipher_byte
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,    // [7:0] plain_byte
    output logic        m_axis_tlast
);

    logic [31:0] seed_reg;
    logic [31:0] offset_reg;
    logic        busy_reg;
    logic [7:0]  cbyte_reg;
    logic        last_reg;
    logic        mval_reg;
    logic [7:0]  mdata_reg;
    logic        mlast_reg;
    logic        in_beat;
    logic        out_free;
    logic        load_out;
    mix_ctl_t    mix_ctl;
    mix_res_t    mix_res;

    assign s_axis_tready = !busy_reg;
    assign in_beat       = s_axis_tvalid && s_axis_tready;
    assign out_free      = !mval_reg || m_axis_tready;
    assign load_out      = mix_res.done && out_free;

    assign mix_ctl.start = in_beat;
    assign mix_ctl.ack   = out_free;

    hkbd_mix u_mix (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (mix_ctl),
        .word  (offset_reg),
        .res   (mix_res)
    );

    // load the seed, advance or restart the offset, track busy and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg   <= '0;
            offset_reg <= '0;
            busy_reg   <= 1'b0;
            mval_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                seed_reg   <= cfg_wdata;
                offset_reg <= cfg_wdata;
            end
            else if (in_beat)
            begin
                offset_reg <= s_axis_tlast ? seed_reg : offset_reg + GOLDEN_STEP;
            end

            if (in_beat)
                busy_reg <= 1'b1;
            else if (load_out)
                busy_reg <= 1'b0;

            if (load_out)
                mval_reg <= 1'b1;
            else if (m_axis_tready)
                mval_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_beat)
        begin
            cbyte_reg <= s_axis_tdata;
            last_reg  <= s_axis_tlast;
        end
        if (load_out)
        begin
            mdata_reg <= decode_byte(cbyte_reg, mix_res.key);
            mlast_reg <= last_reg;
        end
    end

    assign m_axis_tvalid = mval_reg;
    assign m_axis_tdata  = mdata_reg;
    assign m_axis_tlast  = mlast_reg;

endmodule

### rtl/hkbd_checker.sv
// Port-level checker for the hash keystream byte decoder top level.
// Bound to hash_keystream_byte_decoder_top; no package dependency.
module hkbd_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       s_axis_tvalid,
    input logic       s_axis_tready,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata,
    input logic       m_axis_tlast
);

    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input accepted while a beat is in work");

    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !$rose(m_axis_tvalid))
        else $error("result appeared one cycle after acceptance");

    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |-> ##2 !$rose(m_axis_tvalid))
        else $error("result appeared two cycles after acceptance");

    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> s_axis_tready)
        else $error("input not released when result was loaded");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("stalled output beat changed");

endmodule

bind hash_keystream_byte_decoder_top hkbd_checker u_hkbd_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

### dv/hkbd_decode_check_pkg.sv
// Scoreboard package for the hash keystream byte decoder testbench.
// Holds the key word and byte decode predictor and the scoreboard class that
// checks decoded beats against it. No dependencies.
package hkbd_decode_check_pkg;

    localparam logic [31:0] KEY_STEP  = 32'h9e3779b9;
    localparam logic [31:0] KEY_MUL_A = 32'h7feb352d;
    localparam logic [31:0] KEY_MUL_B = 32'h846ca68b;
    localparam int          MAX_SHOWN = 40;

    typedef struct packed {
        logic [7:0] plain;
        logic       last;
    } plain_beat_t;

    function automatic logic [31:0] key_word(logic [31:0] x);
        x = x ^ (x >> 16);
        x = x * KEY_MUL_A;
        x = x ^ (x >> 15);
        x = x * KEY_MUL_B;
        x = x ^ (x >> 16);
        return x;
    endfunction

    function automatic logic [7:0] plain_of(logic [7:0] c, logic [31:0] k);
        logic [7:0] v;
        logic [2:0] r;
        v = (c - k[15:8]) ^ k[7:0];
        r = k[18:16];
        if (r == 3'd0)
        begin
            return v;
        end
        return (v >> r) | (v << (4'd8 - r));
    endfunction

    class decode_scoreboard;
        logic [31:0] seed;
        logic [31:0] offset;
        plain_beat_t plain_q[$];
        int          errors;

        function new();
            seed   = '0;
            offset = '0;
            errors = 0;
        endfunction

        function void load_seed(logic [31:0] s);
            seed   = s;
            offset = s;
        endfunction

        function int pending();
            return plain_q.size();
        endfunction

        function void note_cipher(logic [7:0] c, logic l);
            plain_beat_t b;
            b.plain = plain_of(c, key_word(offset));
            b.last  = l;
            plain_q.push_back(b);
            offset = l ? seed : offset + KEY_STEP;
        endfunction

        task report(string msg);
            errors++;
            if (errors <= MAX_SHOWN)
            begin
                $display("%0t mismatch: %s", $realtime, msg);
            end
        endtask

        task check_plain(logic [7:0] p, logic l);
            plain_beat_t b;
            if (plain_q.size() == 0)
            begin
                report($sformatf("unexpected beat plain=%02h last=%0b", p, l));
                return;
            end
            b = plain_q.pop_front();
            if (p !== b.plain)
            begin
                report($sformatf("plain_byte got %02h want %02h", p, b.plain));
            end
            if (l !== b.last)
            begin
                report($sformatf("last_out got %0b want %0b", l, b.last));
            end
        endtask
    endclass

endpackage

### dv/tb_hash_keystream_byte_decoder_top.sv
// Testbench for hash_keystream_byte_decoder_top: directed and random strings
// under varying stalls, checked by the scoreboard in hkbd_decode_check_pkg.
// Depends on hkbd_decode_check_pkg and the RTL of the decoder.
module tb_hash_keystream_byte_decoder_top;
    import hkbd_decode_check_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 10;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [31:0] cfg_wdata = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;
    logic        m_axis_tlast;

    int unsigned tx_idle_pct = 6;
    int unsigned rx_idle_pct = 71;
    int          cycles = 0;

    decode_scoreboard sb = new();

    hash_keystream_byte_decoder_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                sb.note_cipher(s_axis_tdata, s_axis_tlast);
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                sb.check_plain(m_axis_tdata, m_axis_tlast);
            end
        end
    end

    always @(negedge clk)
    begin
        m_axis_tready = ($urandom_range(99) >= rx_idle_pct);
    end

    task send_cipher(logic [7:0] c, logic l);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            s_axis_tvalid = 1'b0;
            @(negedge clk);
        end
        s_axis_tdata  = c;
        s_axis_tlast  = l;
        s_axis_tvalid = 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!s_axis_tready);
        @(negedge clk);
    endtask

    task drain();
        s_axis_tvalid = 1'b0;
        while (sb.pending() != 0)
        begin
            @(negedge clk);
        end
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task write_seed(logic [31:0] s);
        drain();
        cfg_wdata = s;
        cfg_we    = 1'b1;
        @(negedge clk);
        cfg_we    = 1'b0;
        sb.load_seed(s);
    endtask

    task run_strings(int n_bytes);
        int sent;
        int len;
        bit cut;
        sent = 0;
        while (sent < n_bytes)
        begin
            len = ($urandom_range(9) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 12);
            cut = ($urandom_range(9) == 0);
            for (int i = 0; i < len; i++)
            begin
                send_cipher(8'($urandom_range(255)), (i == len - 1) && !cut);
            end
            sent += len;
            if (cut || $urandom_range(24) == 0)
            begin
                write_seed($urandom);
            end
        end
    endtask

    initial
    begin
        logic [31:0] s;
        logic [31:0] k;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // seed zero straight out of reset
        send_cipher(8'h00, 1'b0);
        send_cipher(8'hff, 1'b0);
        send_cipher(8'h80, 1'b0);
        send_cipher(8'h01, 1'b1);
        send_cipher(8'h55, 1'b0);
        send_cipher(8'haa, 1'b1);

        write_seed(32'hffffffff);
        send_cipher(8'hff, 1'b0);
        send_cipher(8'h00, 1'b0);
        send_cipher(8'h7f, 1'b1);

        // offset wraps to zero on the second byte
        write_seed(32'h61c88647);
        send_cipher(8'h12, 1'b0);
        send_cipher(8'h34, 1'b0);
        send_cipher(8'hfe, 1'b1);

        // find a seed whose first key gives no rotation
        s = 32'h1;
        k = key_word(s);
        while (k[18:16] != 3'd0)
        begin
            s++;
            k = key_word(s);
        end
        write_seed(s);
        send_cipher(8'ha5, 1'b1);
        send_cipher(8'h5a, 1'b1);

        // restart the position mid-string by a seed write
        write_seed(32'h00000001);
        send_cipher(8'h3c, 1'b0);
        send_cipher(8'hc3, 1'b0);
        write_seed(32'h80000000);
        send_cipher(8'h99, 1'b1);

        write_seed($urandom);
        run_strings(460);

        tx_idle_pct = 71;
        rx_idle_pct = 6;
        write_seed(32'h0);
        run_strings(460);

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        write_seed($urandom);
        run_strings(460);

        drain();
        if (sb.errors == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
